FILE: rtl/core/srsw_pkg.sv
// Shared types and codes for the selective-repeat send window.
`timescale 1ns / 1ps
`default_nettype none

package srsw_pkg;

  // Fixed field widths of the stream and configuration beats
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 3;
  localparam int SEQ_OUT_W  = 8;
  localparam int PAY_OUT_W  = 64;
  localparam int OCC_W      = 4;
  localparam int WS_W       = 4;
  localparam int MOD_W      = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 96;

  // Register reset values
  localparam logic [WS_W-1:0]  WINDOW_SIZE_RST = 4'd4;
  localparam logic [MOD_W-1:0] SEQ_MODULUS_RST = 9'd8;

  typedef enum logic [OP_W-1:0] {
    OP_SEND    = 2'd0,
    OP_ACK     = 2'd1,
    OP_TIMEOUT = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_SENT       = 3'd0,
    STAT_FULL       = 3'd1,
    STAT_ACK_TAKEN  = 3'd2,
    STAT_BAD_CKSUM  = 3'd3,
    STAT_ACK_STALE  = 3'd4,
    STAT_RESENT     = 3'd5,
    STAT_TMO_STALE  = 3'd6
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_SIZE = 2'd0,
    CFG_SEQ_MODULUS = 2'd1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED_CHK,
    ST_RED_LOOP,
    ST_OFFSET,
    ST_EXEC,
    ST_SLIDE,
    ST_DONE
  } state_t;

  // Which value the remainder pass is reducing
  typedef enum logic [1:0] {
    RS_BASE,
    RS_NEXT,
    RS_SEQ
  } red_sel_t;

  typedef struct packed {
    status_t                status;
    logic                   send_valid;
    logic [SEQ_OUT_W-1:0]   send_seq;
    logic [PAY_OUT_W-1:0]   send_payload;
    logic                   timer_start;
    logic                   timer_stop;
    logic [SEQ_OUT_W-1:0]   timer_seq;
    logic [SEQ_OUT_W-1:0]   window_base;
    logic [OCC_W-1:0]       in_flight;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/core/srsw_alu.sv
// Shared compare-subtract unit.
`timescale 1ns / 1ps
`default_nettype none

module srsw_alu #(
  parameter int W = 9
) (
  input  wire logic [W-1:0] a,
  input  wire logic [W-1:0] b,
  output logic      [W-1:0] diff,
  output logic              ge
);

  logic borrow;

  assign {borrow, diff} = {1'b0, a} - {1'b0, b};
  assign ge = ~borrow;

endmodule

`default_nettype wire

FILE: rtl/core/srsw_store.sv
// Payload buffer: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module srsw_store #(
  parameter int DEPTH = 8,
  parameter int AW    = 3,
  parameter int DW    = 64
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: rtl/core/srsw_ctrl.sv
// Sequencer, window state and shared-subtractor datapath of the send window.
`timescale 1ns / 1ps
`default_nettype none

module srsw_ctrl import srsw_pkg::*; #(
  parameter int WINDOW_MAX   = 8,
  parameter int SEQ_BITS     = 8,
  parameter int PAYLOAD_BITS = 64,
  localparam int X_W = (SEQ_BITS > SEQ_OUT_W) ? SEQ_BITS : SEQ_OUT_W,
  localparam int U_W = X_W + 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [OP_W-1:0]      in_op,
  input  wire logic [PAY_OUT_W-1:0] in_payload,
  input  wire logic [SEQ_OUT_W-1:0] in_seq,
  input  wire logic                 in_ck,
  input  wire logic [OCC_W-1:0]     win_eff,
  input  wire logic [U_W-1:0]       mod_eff,
  input  wire logic                 mod_wr,
  output logic                      res_valid,
  input  wire logic                 res_ready,
  output res_t                      res_out
);

  localparam int SLOT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int SUM_W  = SLOT_W + 1;
  localparam int CNT_W  = $clog2(X_W);
  localparam logic [SUM_W-1:0]  WMAX_S    = SUM_W'(WINDOW_MAX);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_MAX - 1);

  state_t                  state_r, state_nxt;
  red_sel_t                rsel_r, rsel_nxt;
  op_t                     op_r, op_nxt;
  logic                    ck_r, ck_nxt;
  logic [SEQ_OUT_W-1:0]    seq_in_r, seq_in_nxt;
  logic [PAYLOAD_BITS-1:0] pay_r, pay_nxt;
  logic [X_W-1:0]          red_x_r, red_x_nxt;
  logic [U_W-1:0]          rem_r, rem_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [U_W-1:0]          seq_red_r, seq_red_nxt;
  logic [U_W-1:0]          base_red_r, base_red_nxt;
  logic [U_W-1:0]          next_red_r, next_red_nxt;
  logic [SEQ_BITS-1:0]     base_raw_r, base_raw_nxt;
  logic [SEQ_BITS-1:0]     next_raw_r, next_raw_nxt;
  logic                    red_ok_r, red_ok_nxt;
  logic [U_W-1:0]          off_r, off_nxt;
  logic [SLOT_W-1:0]       head_r, head_nxt;
  logic [OCC_W-1:0]        occ_r, occ_nxt;
  logic [WINDOW_MAX-1:0]   acked_r, acked_nxt;
  res_t                    res_r, res_nxt;
  logic                    pay_mem_r, pay_mem_nxt;

  logic [U_W-1:0]          alu_a, alu_b, alu_diff;
  logic                    alu_ge;
  logic                    red_done;
  logic [U_W-1:0]          red_val;
  logic                    in_win;
  logic [SLOT_W-1:0]       slot_off, slot_tail;
  logic                    wr_en, rd_en;
  logic [PAYLOAD_BITS-1:0] rd_data;

  // Ring slot of head + offset; both operands stay below WINDOW_MAX
  function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] h,
                                                 input logic [SLOT_W-1:0] o);
    logic [SUM_W-1:0] s;
    s = {1'b0, h} + {1'b0, o};
    if (s >= WMAX_S) begin
      s = s - WMAX_S;
    end
    return s[SLOT_W-1:0];
  endfunction

  srsw_alu #(.W(U_W)) u_alu (
    .a    (alu_a),
    .b    (alu_b),
    .diff (alu_diff),
    .ge   (alu_ge)
  );

  srsw_store #(.DEPTH(WINDOW_MAX), .AW(SLOT_W), .DW(PAYLOAD_BITS)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (slot_tail),
    .wr_data (pay_r),
    .rd_en   (rd_en),
    .rd_addr (slot_off),
    .rd_data (rd_data)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign in_win    = (off_r < U_W'(occ_r));
  assign slot_off  = slot_add(head_r, SLOT_W'(off_r));
  assign slot_tail = slot_add(head_r, SLOT_W'(occ_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      rsel_r     <= RS_BASE;
      base_red_r <= '0;
      next_red_r <= '0;
      base_raw_r <= '0;
      next_raw_r <= '0;
      red_ok_r   <= 1'b1;
      head_r     <= '0;
      occ_r      <= '0;
      acked_r    <= '0;
    end else begin
      state_r    <= state_nxt;
      rsel_r     <= rsel_nxt;
      base_red_r <= base_red_nxt;
      next_red_r <= next_red_nxt;
      base_raw_r <= base_raw_nxt;
      next_raw_r <= next_raw_nxt;
      red_ok_r   <= red_ok_nxt;
      head_r     <= head_nxt;
      occ_r      <= occ_nxt;
      acked_r    <= acked_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    ck_r      <= ck_nxt;
    seq_in_r  <= seq_in_nxt;
    pay_r     <= pay_nxt;
    red_x_r   <= red_x_nxt;
    rem_r     <= rem_nxt;
    cnt_r     <= cnt_nxt;
    seq_red_r <= seq_red_nxt;
    off_r     <= off_nxt;
    res_r     <= res_nxt;
    pay_mem_r <= pay_mem_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    rsel_nxt     = rsel_r;
    op_nxt       = op_r;
    ck_nxt       = ck_r;
    seq_in_nxt   = seq_in_r;
    pay_nxt      = pay_r;
    red_x_nxt    = red_x_r;
    rem_nxt      = rem_r;
    cnt_nxt      = cnt_r;
    seq_red_nxt  = seq_red_r;
    base_red_nxt = base_red_r;
    next_red_nxt = next_red_r;
    base_raw_nxt = base_raw_r;
    next_raw_nxt = next_raw_r;
    red_ok_nxt   = red_ok_r;
    off_nxt      = off_r;
    head_nxt     = head_r;
    occ_nxt      = occ_r;
    acked_nxt    = acked_r;
    res_nxt      = res_r;
    pay_mem_nxt  = pay_mem_r;
    alu_a        = '0;
    alu_b        = mod_eff;
    red_done     = 1'b0;
    red_val      = '0;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    res_valid    = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt     = op_t'(in_op);
          ck_nxt     = in_ck;
          seq_in_nxt = in_seq;
          pay_nxt    = in_payload[PAYLOAD_BITS-1:0];
          if (op_t'(in_op) != OP_NONE) begin
            state_nxt = ST_RED_CHK;
            if (red_ok_r && !mod_wr) begin
              rsel_nxt  = RS_SEQ;
              red_x_nxt = X_W'(in_seq);
            end else begin
              rsel_nxt  = RS_BASE;
              red_x_nxt = X_W'(base_raw_r);
            end
          end
        end
      end
      ST_RED_CHK: begin
        // already below the modulus: no remainder pass
        alu_a = {1'b0, red_x_r};
        if (!alu_ge) begin
          red_done = 1'b1;
          red_val  = alu_a;
        end else begin
          rem_nxt   = '0;
          cnt_nxt   = CNT_W'(X_W - 1);
          state_nxt = ST_RED_LOOP;
        end
      end
      ST_RED_LOOP: begin
        // restoring remainder, one bit per cycle, MSB first
        alu_a   = {rem_r[U_W-2:0], red_x_r[cnt_r]};
        red_val = alu_ge ? alu_diff : alu_a;
        rem_nxt = red_val;
        if (cnt_r == '0) begin
          red_done = 1'b1;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_OFFSET: begin
        alu_a   = seq_red_r;
        alu_b   = base_red_r;
        off_nxt = alu_ge ? alu_diff : alu_diff + mod_eff;
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        res_nxt        = '0;
        res_nxt.status = STAT_SENT;
        pay_mem_nxt    = 1'b0;
        state_nxt      = ST_DONE;
        case (op_r)
          OP_SEND: begin
            alu_a = next_red_r + 1'b1;
            if (occ_r >= win_eff) begin
              res_nxt.status = STAT_FULL;
            end else begin
              wr_en                  = 1'b1;
              acked_nxt[slot_tail]   = 1'b0;
              occ_nxt                = occ_r + 1'b1;
              res_nxt.send_valid     = 1'b1;
              res_nxt.send_seq       = SEQ_OUT_W'(next_red_r);
              res_nxt.send_payload   = PAY_OUT_W'(pay_r);
              res_nxt.timer_start    = 1'b1;
              res_nxt.timer_seq      = SEQ_OUT_W'(next_red_r);
              next_red_nxt           = alu_ge ? '0 : alu_a;
              next_raw_nxt           = SEQ_BITS'(alu_ge ? '0 : alu_a);
            end
          end
          OP_ACK: begin
            if (!ck_r) begin
              res_nxt.status = STAT_BAD_CKSUM;
            end else if (in_win && !acked_r[slot_off]) begin
              acked_nxt[slot_off] = 1'b1;
              res_nxt.status      = STAT_ACK_TAKEN;
              res_nxt.timer_stop  = 1'b1;
              res_nxt.timer_seq   = SEQ_OUT_W'(seq_red_r);
              state_nxt           = ST_SLIDE;
            end else begin
              res_nxt.status = STAT_ACK_STALE;
            end
          end
          OP_TIMEOUT: begin
            if (in_win && !acked_r[slot_off]) begin
              rd_en               = 1'b1;
              pay_mem_nxt         = 1'b1;
              res_nxt.status      = STAT_RESENT;
              res_nxt.send_valid  = 1'b1;
              res_nxt.send_seq    = SEQ_OUT_W'(seq_red_r);
              res_nxt.timer_start = 1'b1;
              res_nxt.timer_seq   = SEQ_OUT_W'(seq_red_r);
            end else begin
              res_nxt.status = STAT_TMO_STALE;
            end
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_SLIDE: begin
        // release one acked packet from the front per cycle
        alu_a = base_red_r + 1'b1;
        if (occ_r != '0 && acked_r[head_r]) begin
          acked_nxt[head_r] = 1'b0;
          head_nxt          = (head_r == SLOT_LAST) ? '0 : head_r + 1'b1;
          occ_nxt           = occ_r - 1'b1;
          base_red_nxt      = alu_ge ? '0 : alu_a;
        end else begin
          base_raw_nxt = SEQ_BITS'(base_red_r);
          state_nxt    = ST_DONE;
        end
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (red_done) begin
      case (rsel_r)
        RS_BASE: begin
          base_red_nxt = red_val;
          rsel_nxt     = RS_NEXT;
          red_x_nxt    = X_W'(next_raw_r);
          state_nxt    = ST_RED_CHK;
        end
        RS_NEXT: begin
          next_red_nxt = red_val;
          red_ok_nxt   = 1'b1;
          rsel_nxt     = RS_SEQ;
          red_x_nxt    = X_W'(seq_in_r);
          state_nxt    = ST_RED_CHK;
        end
        default: begin
          seq_red_nxt = red_val;
          state_nxt   = ST_OFFSET;
        end
      endcase
    end

    // cached base and next no longer match the modulus
    if (mod_wr) begin
      red_ok_nxt = 1'b0;
    end
  end

  always_comb begin
    res_out             = res_r;
    res_out.window_base = SEQ_OUT_W'(base_red_r);
    res_out.in_flight   = occ_r;
    if (pay_mem_r) begin
      res_out.send_payload = PAY_OUT_W'(rd_data);
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(occ_r) <= WINDOW_MAX)
    else $error("occupancy beyond buffer depth");

  a_exec_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EXEC |-> (seq_red_r < mod_eff && base_red_r < mod_eff &&
                            next_red_r < mod_eff && off_r < mod_eff))
    else $error("sequence value not reduced below modulus at execute");

  a_slide_front: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(state_r) == ST_SLIDE && state_r == ST_DONE) |->
      (occ_r == '0 || !acked_r[head_r]))
    else $error("window stopped sliding on an acked front entry");

endmodule

`default_nettype wire

FILE: rtl/core/selective_repeat_send_window.sv
// Top level of the selective-repeat send window: ports, registers, output stage.
`timescale 1ns / 1ps
`default_nettype none

// Sender half of a selective-repeat ARQ link. Each input beat is one event:
// send a new payload, an acknowledgement, or a timer expiry; each event except
// operation code 3 (dropped silently) yields exactly one result beat with a
// status, an optional packet to transmit, an optional timer start or stop and
// the window base and fill after the event. Payloads sit in a WINDOW_MAX-deep
// buffer; ack marks are one flop per slot. Flow: each event passes through
// idle, sequence check, window offset, execute and hand-off to the output
// register before the next event can be accepted, the modulus compares and
// subtractions running on one shared compare-subtract unit. A sequence number
// at or above the modulus adds a bit-serial remainder pass over X_W bits
// (X_W = max(SEQ_BITS, 8)). An accepted ack adds a slide step that releases
// the acked packets at the front of the window. The first event after a write
// of seq_modulus first re-reduces the stored base and next numbers. The output
// register lets the next event start while a result waits on out_tready.
// Configuration beats are taken at any time (cfg_ready is tied high) but
// belong in idle periods.
module selective_repeat_send_window import srsw_pkg::*; #(
  parameter int WINDOW_MAX   = 8,
  parameter int SEQ_BITS     = 8,
  parameter int PAYLOAD_BITS = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input stream
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // [63:0] payload, [71:64] seq_num, [72] checksum_ok, [79:73] zero
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // [1:0] operation
  input  wire logic [OP_W-1:0]       in_tuser,
  // result stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [0] send_valid, [8:1] send_seq, [72:9] send_payload, [73] timer_start,
  // [74] timer_stop, [82:75] timer_seq, [90:83] window_base,
  // [94:91] in_flight, [95] zero
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // [2:0] status
  output logic [STATUS_W-1:0]        out_tuser,
  // configuration writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [MOD_W-1:0]      cfg_data
);

  localparam int X_W = (SEQ_BITS > SEQ_OUT_W) ? SEQ_BITS : SEQ_OUT_W;
  localparam int U_W = X_W + 1;
  localparam logic [6:0]  WMAX7   = 7'(WINDOW_MAX);
  localparam logic [16:0] MOD_CAP = 17'(1 << SEQ_BITS);

  logic [WS_W-1:0]  win_size_r, win_size_nxt;
  logic [MOD_W-1:0] seq_mod_r, seq_mod_nxt;
  logic             mod_wr;
  logic [OCC_W-1:0] win_eff;
  logic [U_W-1:0]   mod_eff;

  logic             res_valid, res_ready;
  res_t             res;
  logic             out_valid_r, out_valid_nxt;
  res_t             out_res_r, out_res_nxt;

  // Configuration registers; every beat is taken at once
  assign cfg_ready = 1'b1;

  always_comb begin
    win_size_nxt = win_size_r;
    seq_mod_nxt  = seq_mod_r;
    mod_wr       = 1'b0;
    if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_WINDOW_SIZE: win_size_nxt = cfg_data[WS_W-1:0];
        CFG_SEQ_MODULUS: begin
          seq_mod_nxt = cfg_data;
          mod_wr      = 1'b1;
        end
        default: ; // unknown index: drop the beat
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_size_r <= WINDOW_SIZE_RST;
      seq_mod_r  <= SEQ_MODULUS_RST;
    end else begin
      win_size_r <= win_size_nxt;
      seq_mod_r  <= seq_mod_nxt;
    end
  end

  // Clamp the window to 1..WINDOW_MAX
  assign win_eff = (win_size_r == '0) ? OCC_W'(1) :
                   ({3'b0, win_size_r} > WMAX7) ? WMAX7[OCC_W-1:0] : win_size_r;

  // Clamp the modulus to 2..2^SEQ_BITS
  assign mod_eff = (seq_mod_r < MOD_W'(2)) ? U_W'(2) :
                   ({8'b0, seq_mod_r} > MOD_CAP) ? U_W'(MOD_CAP) : U_W'(seq_mod_r);

  srsw_ctrl #(
    .WINDOW_MAX   (WINDOW_MAX),
    .SEQ_BITS     (SEQ_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_op      (in_tuser),
    .in_payload (in_tdata[63:0]),
    .in_seq     (in_tdata[71:64]),
    .in_ck      (in_tdata[72]),
    .win_eff    (win_eff),
    .mod_eff    (mod_eff),
    .mod_wr     (mod_wr),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_out    (res)
  );

  // Output register: load whenever it is empty or its beat leaves this cycle
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {1'b0,
                       out_res_r.in_flight,
                       out_res_r.window_base,
                       out_res_r.timer_seq,
                       out_res_r.timer_stop,
                       out_res_r.timer_start,
                       out_res_r.send_payload,
                       out_res_r.send_seq,
                       out_res_r.send_valid};

endmodule

`default_nettype wire

FILE: tb/sv/tb_selective_repeat_send_window.sv
// Self-checking stream testbench for the selective-repeat send window.
`timescale 1ns / 1ps

module tb_selective_repeat_send_window;
  import srsw_pkg::*;

  localparam int SLOTS          = 8;     // buffer depth, same as the block's WINDOW_MAX
  localparam int SEQ_SPAN       = 256;   // 2^SEQ_BITS
  localparam int RESET_CYCLES   = 8;
  // Worst event: base steps, remainder pass, full slide and re-reduction; round up.
  localparam int SETTLE_CYCLES  = 64;
  // Longest quiet stretch: receiver hold-off plus a phase gap, taken several times.
  localparam int STALL_LIMIT    = 4000;
  localparam int RAND_PHASES    = 10;
  localparam int EVENTS_PER_PHASE = 135;
  localparam int IDLE_PCT       = 28;
  localparam int HOLD_START     = 2500;
  localparam int HOLD_LEN       = 400;
  localparam int CALM_START     = 9000;
  localparam int CALM_LEN       = 3000;

  typedef struct {
    op_t         op;
    logic [63:0] payload;
    logic [7:0]  seq;
    logic        cksum_ok;
  } win_event_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [OP_W-1:0]       in_tuser = OP_NONE;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]   out_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_WINDOW_SIZE;
  logic [MOD_W-1:0]      cfg_data = '0;

  selective_repeat_send_window uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  // Shadow of the sender: registers, payload buffer, ack marks and window pointers
  logic [WS_W-1:0]  reg_window  = WINDOW_SIZE_RST;
  logic [MOD_W-1:0] reg_modulus = SEQ_MODULUS_RST;
  logic [63:0]      win_payload [SLOTS];
  bit               win_acked   [SLOTS];
  int               win_head = 0;
  int               win_occ  = 0;
  int               win_base = 0;
  int               win_next = 0;

  win_event_t event_queue[$];     // beats waiting for the driver
  res_t       report_queue[$];    // result beats the block owes us
  win_event_t tx_event;
  res_t       want_report;
  int         error_count = 0;
  int         cycle_count = 0;
  int         rx_cycle = 0;
  int         stall_cycles = 0;
  bit         in_beat_taken = 1'b0;

  function automatic int eff_window();
    if (reg_window == 0) return 1;
    if (int'(reg_window) > SLOTS) return SLOTS;
    return int'(reg_window);
  endfunction

  function automatic int eff_modulus();
    if (reg_modulus < 2) return 2;
    if (int'(reg_modulus) > SEQ_SPAN) return SEQ_SPAN;
    return int'(reg_modulus);
  endfunction

  // Apply one accepted event to the shadow window and queue the report it owes.
  task automatic track_window_event(op_t op, logic [63:0] pay, logic [7:0] seq_in, logic ck);
    int   m;
    int   seq;
    int   base;
    int   offs;
    int   slot;
    int   n;
    res_t r;
    if (op == OP_NONE) return;
    m    = eff_modulus();
    seq  = int'(seq_in) % m;
    base = win_base % m;
    offs = (seq + m - base) % m;
    slot = (win_head + offs) % SLOTS;
    r    = '0;
    case (op)
      OP_SEND: begin
        if (win_occ >= eff_window()) begin
          r.status = STAT_FULL;
        end else begin
          n = win_next % m;
          win_payload[(win_head + win_occ) % SLOTS] = pay;
          win_acked[(win_head + win_occ) % SLOTS]   = 1'b0;
          win_occ++;
          r.status       = STAT_SENT;
          r.send_valid   = 1'b1;
          r.send_seq     = 8'(n);
          r.send_payload = pay;
          r.timer_start  = 1'b1;
          r.timer_seq    = 8'(n);
          win_next       = (n + 1) % m;
        end
      end
      OP_ACK: begin
        if (!ck) begin
          r.status = STAT_BAD_CKSUM;
        end else if (offs < win_occ && !win_acked[slot]) begin
          win_acked[slot] = 1'b1;
          r.status     = STAT_ACK_TAKEN;
          r.timer_stop = 1'b1;
          r.timer_seq  = 8'(seq);
          // Slide past every acked packet at the front
          while (win_occ > 0 && win_acked[win_head]) begin
            win_acked[win_head] = 1'b0;
            win_head = (win_head + 1) % SLOTS;
            win_occ--;
            base = (base + 1) % m;
          end
          win_base = base;
        end else begin
          r.status = STAT_ACK_STALE;
        end
      end
      default: begin
        if (offs < win_occ && !win_acked[slot]) begin
          r.status       = STAT_RESENT;
          r.send_valid   = 1'b1;
          r.send_seq     = 8'(seq);
          r.send_payload = win_payload[slot];
          r.timer_start  = 1'b1;
          r.timer_seq    = 8'(seq);
        end else begin
          r.status = STAT_TMO_STALE;
        end
      end
    endcase
    r.window_base = 8'(win_base % m);
    r.in_flight   = 4'(win_occ);
    report_queue.insert(report_queue.size(), r);
  endtask

  task automatic queue_event(op_t op, logic [63:0] pay, logic [7:0] seq, logic ck);
    win_event_t e;
    e.op       = op;
    e.payload  = pay;
    e.seq      = seq;
    e.cksum_ok = ck;
    event_queue.insert(event_queue.size(), e);
  endtask

  // Aim a sequence number at the live window most of the time, sometimes one
  // past it, sometimes aliased above the modulus, sometimes anywhere.
  function automatic logic [7:0] aim_seq();
    int m;
    int pick;
    int target;
    m    = eff_modulus();
    pick = $urandom_range(0, 99);
    if (pick < 10) return 8'($urandom_range(0, 255));
    target = (win_base % m + $urandom_range(0, win_occ)) % m;
    if (pick < 25 && (255 - target) / m >= 1)
      target += m * $urandom_range(1, (255 - target) / m);
    return 8'(target);
  endfunction

  task automatic write_register(cfg_idx_t idx, logic [MOD_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_WINDOW_SIZE) reg_window = value[WS_W-1:0];
    else reg_modulus = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Hold until every beat is out and answered, then let the block settle.
  task automatic wait_quiet();
    while (event_queue.size() != 0 || in_tvalid || report_queue.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      error_count++;
    end
  endtask

  // Sample handshakes at the rising edge; predict on every accepted input beat.
  always @(posedge clk) begin
    cycle_count++;
    in_beat_taken = in_tvalid && in_tready;
    if (in_beat_taken)
      track_window_event(op_t'(in_tuser), in_tdata[63:0], in_tdata[71:64], in_tdata[72]);
    if (in_beat_taken || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Driver: hold a beat until taken, then drive the next one or go idle.
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_beat_taken)) begin
      if (event_queue.size() != 0 &&
          ((cycle_count >= CALM_START && cycle_count < CALM_START + CALM_LEN) ||
           $urandom_range(0, 99) >= IDLE_PCT)) begin
        tx_event = event_queue[0];
        event_queue.delete(0);
        in_tvalid <= 1'b1;
        in_tuser  <= tx_event.op;
        in_tdata  <= {7'b0, tx_event.cksum_ok, tx_event.seq, tx_event.payload};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure: one long hold-off so the block fills and stalls its
  // input, one calm stretch, random gaps elsewhere.
  always @(negedge clk) begin
    rx_cycle++;
    if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN)
      out_tready <= 1'b0;
    else if (rx_cycle >= CALM_START && rx_cycle < CALM_START + CALM_LEN)
      out_tready <= 1'b1;
    else
      out_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Monitor: compare each result beat with the oldest report owed.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (report_queue.size() == 0) begin
        $error("result beat with no expectation waiting");
        error_count++;
      end else begin
        want_report = report_queue[0];
        report_queue.delete(0);
        check_field("status",       64'(want_report.status),       64'(out_tuser));
        check_field("send_valid",   64'(want_report.send_valid),   64'(out_tdata[0]));
        check_field("send_seq",     64'(want_report.send_seq),     64'(out_tdata[8:1]));
        check_field("send_payload", want_report.send_payload,      out_tdata[72:9]);
        check_field("timer_start",  64'(want_report.timer_start),  64'(out_tdata[73]));
        check_field("timer_stop",   64'(want_report.timer_stop),   64'(out_tdata[74]));
        check_field("timer_seq",    64'(want_report.timer_seq),    64'(out_tdata[82:75]));
        check_field("window_base",  64'(want_report.window_base),  64'(out_tdata[90:83]));
        check_field("in_flight",    64'(want_report.in_flight),    64'(out_tdata[94:91]));
      end
    end
  end

  initial begin
    int ph;
    int count;
    int pick;
    int win_val;
    int mod_val;
    logic [63:0] pay;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed, reset registers: fill to full, payload extremes, bad checksum,
    // out-of-order ack, repeated ack, timeouts for acked / unacked / outside
    // packets, numbers above the modulus, a dropped operation code, a slide.
    queue_event(OP_SEND,    64'h0,                  8'd0,   1'b0);
    queue_event(OP_SEND,    '1,                     8'd255, 1'b1);
    queue_event(OP_SEND,    64'h0123_4567_89AB_CDEF, 8'd0,  1'b0);
    queue_event(OP_SEND,    64'h8000_0000_0000_0001, 8'd0,  1'b1);
    queue_event(OP_SEND,    64'h5555_5555_5555_5555, 8'd0,  1'b0);
    queue_event(OP_ACK,     '1,                     8'd1,   1'b0);
    queue_event(OP_ACK,     64'h0,                  8'd2,   1'b1);
    queue_event(OP_ACK,     64'h0,                  8'd2,   1'b1);
    queue_event(OP_TIMEOUT, 64'h0,                  8'd2,   1'b0);
    queue_event(OP_TIMEOUT, 64'h0,                  8'd3,   1'b1);
    queue_event(OP_TIMEOUT, 64'h0,                  8'd5,   1'b0);
    queue_event(OP_ACK,     64'h0,                  8'd6,   1'b1);
    queue_event(OP_ACK,     64'h0,                  8'd8,   1'b1);
    queue_event(OP_NONE,    '1,                     8'd255, 1'b1);
    queue_event(OP_ACK,     64'h0,                  8'd255, 1'b1);
    queue_event(OP_ACK,     64'h0,                  8'd1,   1'b1);
    queue_event(OP_TIMEOUT, 64'h0,                  8'd251, 1'b1);
    queue_event(OP_SEND,    64'hAAAA_AAAA_AAAA_AAAA, 8'd0,  1'b0);
    wait_quiet();

    // Shrink the window below the packets in flight: sends refused until drained.
    write_register(CFG_WINDOW_SIZE, 9'd1);
    queue_event(OP_SEND,    64'h1111_2222_3333_4444, 8'd0,  1'b0);
    queue_event(OP_ACK,     64'h0,                  8'd4,   1'b1);
    queue_event(OP_ACK,     64'h0,                  8'd3,   1'b1);
    queue_event(OP_SEND,    64'hFEDC_BA98_7654_3210, 8'd0,  1'b0);
    wait_quiet();

    // Change the modulus with a packet in flight; window above the maximum.
    write_register(CFG_WINDOW_SIZE, 9'd15);
    write_register(CFG_SEQ_MODULUS, 9'd3);
    queue_event(OP_TIMEOUT, 64'h0,                  8'd2,   1'b0);
    queue_event(OP_SEND,    64'hDEAD_BEEF_CAFE_F00D, 8'd0,  1'b1);
    queue_event(OP_ACK,     64'h0,                  8'd5,   1'b1);
    wait_quiet();

    // Random phases: extremes first, then random settings.
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: begin win_val = 0;  mod_val = 1;   end
        1: begin win_val = 8;  mod_val = 256; end
        2: begin win_val = 1;  mod_val = 0;   end
        3: begin win_val = 15; mod_val = 511; end
        4: begin win_val = 3;  mod_val = 5;   end
        5: begin win_val = 8;  mod_val = 3;   end
        6: begin win_val = 2;  mod_val = 200; end
        7: begin win_val = 5;  mod_val = 9;   end
        default: begin
          win_val = $urandom_range(0, 15);
          mod_val = $urandom_range(0, 511);
        end
      endcase
      write_register(CFG_WINDOW_SIZE, 9'(win_val));
      write_register(CFG_SEQ_MODULUS, 9'(mod_val));
      count = 0;
      while (count < EVENTS_PER_PHASE) begin
        // Generate lazily so the aim follows the live window state.
        while (event_queue.size() != 0) @(posedge clk);
        pay  = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 42)
          queue_event(OP_SEND, pay, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        else if (pick < 72)
          queue_event(OP_ACK, pay, aim_seq(), ($urandom_range(0, 99) < 85));
        else if (pick < 95)
          queue_event(OP_TIMEOUT, pay, aim_seq(), 1'($urandom_range(0, 1)));
        else
          queue_event(OP_NONE, pay, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        if (pick < 95) count++;
      end
      wait_quiet();
    end

    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: selective_repeat_send_window.f
rtl/core/srsw_pkg.sv
rtl/core/srsw_alu.sv
rtl/core/srsw_store.sv
rtl/core/srsw_ctrl.sv
rtl/core/selective_repeat_send_window.sv
tb/sv/tb_selective_repeat_send_window.sv
